### rtl/melody_tone_sequencer_assert.svh
// assertion macros used by the checker file of the melody tone sequencer
// no dependencies; the user module must have i_clk and i_rst_n in scope
`ifndef MELODY_TONE_SEQUENCER_ASSERT_SVH
`define MELODY_TONE_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define MTS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("melody tone sequencer assertion failed");

// next-cycle implication
`define MTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("melody tone sequencer assertion failed");

`endif

### rtl/mts_pkg.sv
// shared types, constants and helpers of the melody tone sequencer
// used by the top, controller, datapath and checker files; depends on nothing
`timescale 1ns / 1ps

package mts_pkg;

    // default structure sizes
    localparam int NOTE_DEPTH_DEF = 64;
    localparam int FREQ_BITS_DEF  = 16;

    // field widths
    localparam int CMD_W      = 2;
    localparam int IDX_W      = 6;
    localparam int FREQ_W     = 16;
    localparam int TICKS_W    = 8;
    localparam int LEN_W      = 7;
    localparam int CLK_W      = 27;
    localparam int DUTY_W     = 8;
    localparam int TOP_W      = 8;
    localparam int SEL_W      = 3;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY  = 1'b1;

    localparam logic [CLK_W-1:0]  CLOCK_RESET = 27'd16000000;
    localparam logic [DUTY_W-1:0] DUTY_RESET  = 8'd2;

    // prescaler codes 1..7 stand for 1, 8, 32, 64, 128, 256, 1024
    localparam int NUM_PRE = 7;
    // log2 of twice each prescaler
    localparam int PRE_SHIFT [NUM_PRE] = '{1, 4, 6, 7, 8, 9, 11};
    localparam logic [SEL_W-1:0] SEL_RESET    = 3'd1;
    localparam logic [SEL_W-1:0] SEL_FALLBACK = 3'd7;
    localparam logic [TOP_W-1:0] TOP_MAX      = 8'd255;
    localparam logic [TICKS_W-1:0] ELAPSED_MAX = 8'd255;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_START = 2'd2,
        CMD_STOP  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DEC,
        ST_CHK,
        ST_RD2,
        ST_NOTE,
        ST_DIV1,
        ST_SEL,
        ST_D2GO,
        ST_DIV2,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic wr_note;
        logic start;
        logic stop;
        logic idle_tick;
        logic tick;
        logic rd_req;
        logic chk;
        logic rest;
        logic div_first;
        logic sel;
        logic div_second;
        logic fin;
        logic emit;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        t_cmd cmd;
        logic busy;
        logic tick_end;
        logic rest;
        logic div_done;
        logic out_free;
    } t_sts;

    // value modulo depth for values below 256, by conditional subtraction of
    // shifted multiples of depth
    function automatic logic [10:0] f_wrap(input logic [7:0] value, input int depth);
        logic [10:0] v;
        v = {3'b000, value};
        for (int j = 7; j >= 0; j--) begin
            if ((depth << j) <= 255 && v >= 11'(depth << j)) begin
                v = v - 11'(depth << j);
            end
        end
        return v;
    endfunction

endpackage

### rtl/melody_tone_sequencer.sv
// a tick that sounds a note runs two 27-step passes of the shared bit-serial divider
// (clock over frequency, then top over duty); a tick on a rest passes DEC, CHK, RD2
// and NOTE before EMIT, a tick that ends the sound DEC and CHK, any other item DEC only
// one item is in flight; the next is accepted in the cycle after the result is registered,
// even while that result waits for ready; the note ram has no reset, undefined till written
// reset: synchronous active low; not on item, candidate, output data or divider data registers
`timescale 1ns / 1ps

module melody_tone_sequencer #(
    parameter int NOTE_DEPTH = mts_pkg::NOTE_DEPTH_DEF,
    parameter int FREQ_BITS  = mts_pkg::FREQ_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input items
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // entry_index, note_freq, note_ticks, sound_length, zero fill
    input  logic [mts_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // command
    input  logic [mts_pkg::CMD_W-1:0]          i_s_axis_tuser,
    // result items
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // pwm_enable, top_value, clock_select, compare_value, playing, finished, zero fill
    output logic [mts_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mts_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mts_pkg::CLK_W-1:0]          i_cfg_data
);

    mts_pkg::t_ctl w_ctl;
    mts_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    mts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    mts_dp #(
        .NOTE_DEPTH (NOTE_DEPTH),
        .FREQ_BITS  (FREQ_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .o_sts          (w_sts),
        .i_command      (mts_pkg::t_cmd'(i_s_axis_tuser)),
        .i_entry_index  (i_s_axis_tdata[5:0]),
        .i_note_freq    (i_s_axis_tdata[21:6]),
        .i_note_ticks   (i_s_axis_tdata[29:22]),
        .i_sound_length (i_s_axis_tdata[36:30]),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .o_out_data     (o_m_axis_tdata)
    );

endmodule

### rtl/mts_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module mts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/mts_div.sv
// serial restoring divider, one quotient bit per cycle
// no package dependencies
`timescale 1ns / 1ps

module mts_div #(
    parameter int DW = 27,
    parameter int VW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quo
);

    localparam int CW = $clog2(DW + 1);

    logic          r_run;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [VW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_dvs;

    logic [VW:0]   w_shift;
    logic [VW:0]   w_diff;
    logic          w_ge;

    always_comb begin
        w_shift = {r_rem, r_quo[DW-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
        w_ge    = !w_diff[VW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CW'(DW);
            end else if (r_run) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_run) begin
            r_rem <= w_ge ? w_diff[VW-1:0] : w_shift[VW-1:0];
            r_quo <= {r_quo[DW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

### rtl/mts_ctrl.sv
// controller state machine of the melody tone sequencer
// depends on mts_pkg for the state, command and status types
`timescale 1ns / 1ps

module mts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mts_pkg::t_sts i_sts,
    output mts_pkg::t_ctl o_ctl
);

    mts_pkg::t_state r_state;
    mts_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mts_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_in_ready = (r_state == mts_pkg::ST_IDLE);
        unique case (r_state)
            mts_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = mts_pkg::ST_DEC;
                end
            end
            mts_pkg::ST_DEC: begin
                unique case (i_sts.cmd)
                    mts_pkg::CMD_WRITE: begin
                        o_ctl.wr_note = 1'b1;
                        n_state       = mts_pkg::ST_EMIT;
                    end
                    mts_pkg::CMD_START: begin
                        o_ctl.start = 1'b1;
                        n_state     = mts_pkg::ST_EMIT;
                    end
                    mts_pkg::CMD_STOP: begin
                        o_ctl.stop = 1'b1;
                        n_state    = mts_pkg::ST_EMIT;
                    end
                    mts_pkg::CMD_TICK: begin
                        if (!i_sts.busy) begin
                            o_ctl.idle_tick = 1'b1;
                            n_state         = mts_pkg::ST_EMIT;
                        end else begin
                            // read the current note while elapsed updates
                            o_ctl.tick   = 1'b1;
                            o_ctl.rd_req = 1'b1;
                            n_state      = mts_pkg::ST_CHK;
                        end
                    end
                    default: n_state = mts_pkg::ST_EMIT;
                endcase
            end
            mts_pkg::ST_CHK: begin
                o_ctl.chk = 1'b1;
                n_state   = i_sts.tick_end ? mts_pkg::ST_EMIT : mts_pkg::ST_RD2;
            end
            mts_pkg::ST_RD2: begin
                // re-read at the possibly advanced position
                o_ctl.rd_req = 1'b1;
                n_state      = mts_pkg::ST_NOTE;
            end
            mts_pkg::ST_NOTE: begin
                if (i_sts.rest) begin
                    o_ctl.rest = 1'b1;
                    n_state    = mts_pkg::ST_EMIT;
                end else begin
                    o_ctl.div_first = 1'b1;
                    n_state         = mts_pkg::ST_DIV1;
                end
            end
            mts_pkg::ST_DIV1: begin
                if (i_sts.div_done) begin
                    n_state = mts_pkg::ST_SEL;
                end
            end
            mts_pkg::ST_SEL: begin
                o_ctl.sel = 1'b1;
                n_state   = mts_pkg::ST_D2GO;
            end
            mts_pkg::ST_D2GO: begin
                o_ctl.div_second = 1'b1;
                n_state          = mts_pkg::ST_DIV2;
            end
            mts_pkg::ST_DIV2: begin
                if (i_sts.div_done) begin
                    o_ctl.fin = 1'b1;
                    n_state   = mts_pkg::ST_EMIT;
                end
            end
            mts_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_ctl.emit = 1'b1;
                    n_state    = mts_pkg::ST_IDLE;
                end
            end
            default: n_state = mts_pkg::ST_IDLE;
        endcase
    end

endmodule

### rtl/mts_dp.sv
// datapath: sequencing registers, note ram, shared divider, tone choice,
// configuration registers and output register; uses mts_pkg, mts_ram, mts_div
`timescale 1ns / 1ps

module mts_dp #(
    parameter int NOTE_DEPTH = mts_pkg::NOTE_DEPTH_DEF,
    parameter int FREQ_BITS  = mts_pkg::FREQ_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mts_pkg::t_ctl                      i_ctl,
    output mts_pkg::t_sts                      o_sts,
    // input item fields
    input  mts_pkg::t_cmd                      i_command,
    input  logic [mts_pkg::IDX_W-1:0]          i_entry_index,
    input  logic [mts_pkg::FREQ_W-1:0]         i_note_freq,
    input  logic [mts_pkg::TICKS_W-1:0]        i_note_ticks,
    input  logic [mts_pkg::LEN_W-1:0]          i_sound_length,
    // configuration writes
    input  logic                               i_cfg_valid,
    input  logic [mts_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mts_pkg::CLK_W-1:0]          i_cfg_data,
    // result register
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [mts_pkg::OUT_DATA_W-1:0]     o_out_data
);

    localparam int AW  = $clog2(NOTE_DEPTH);
    localparam int RW  = FREQ_BITS + mts_pkg::TICKS_W;
    localparam int CKW = mts_pkg::CLK_W;

    // latched item
    mts_pkg::t_cmd                 r_cmd;
    logic [mts_pkg::IDX_W-1:0]     r_idx;
    logic [FREQ_BITS-1:0]          r_freq;
    logic [mts_pkg::TICKS_W-1:0]   r_ticks;
    logic [mts_pkg::LEN_W-1:0]     r_len_in;

    // sequencing state
    logic [mts_pkg::IDX_W-1:0]     r_start_idx;
    logic [mts_pkg::LEN_W-1:0]     r_len;
    logic [mts_pkg::LEN_W-1:0]     r_pos;
    logic [mts_pkg::TICKS_W-1:0]   r_elapsed;
    logic                          r_busy;
    logic                          r_pending;
    logic                          r_fin;

    // tone state
    logic                          r_en;
    logic [mts_pkg::TOP_W-1:0]     r_top;
    logic [mts_pkg::SEL_W-1:0]     r_sel;
    logic [mts_pkg::TOP_W-1:0]     r_cmp;
    logic [mts_pkg::TOP_W-1:0]     r_cand_top;
    logic [mts_pkg::SEL_W-1:0]     r_cand_sel;

    // configuration
    logic [CKW-1:0]                r_clk_hz;
    logic [mts_pkg::DUTY_W-1:0]    r_duty;

    logic                          r_out_valid;
    logic [mts_pkg::OUT_DATA_W-1:0] r_out_data;

    logic [10:0]                   w_waddr_full;
    logic [10:0]                   w_raddr_full;
    logic [RW-1:0]                 w_rdata;
    logic [mts_pkg::TICKS_W-1:0]   w_dur;
    logic [FREQ_BITS-1:0]          w_note_freq;
    logic [mts_pkg::LEN_W-1:0]     w_pos_inc;
    logic                          w_reached;
    logic [mts_pkg::DUTY_W-1:0]    w_duty;
    logic                          w_div_start;
    logic [CKW-1:0]                w_div_dividend;
    logic [FREQ_BITS-1:0]          w_div_divisor;
    logic                          w_div_done;
    logic [CKW-1:0]                w_div_quo;
    logic [CKW-1:0]                w_q;
    logic [mts_pkg::TOP_W-1:0]     w_best_top;
    logic [mts_pkg::SEL_W-1:0]     w_best_sel;

    // note addressing wraps modulo the ram depth
    always_comb begin
        w_waddr_full = mts_pkg::f_wrap({2'b00, r_idx}, NOTE_DEPTH);
        w_raddr_full = mts_pkg::f_wrap({2'b00, r_start_idx} + {1'b0, r_pos}, NOTE_DEPTH);
    end

    mts_ram #(
        .WIDTH (RW),
        .DEPTH (NOTE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.wr_note),
        .i_waddr (w_waddr_full[AW-1:0]),
        .i_wdata ({r_freq, r_ticks}),
        .i_re    (i_ctl.rd_req),
        .i_raddr (w_raddr_full[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_dur       = w_rdata[mts_pkg::TICKS_W-1:0];
        w_note_freq = w_rdata[RW-1:mts_pkg::TICKS_W];
        w_pos_inc   = r_pos + mts_pkg::LEN_W'(1);
        w_reached   = (r_elapsed >= w_dur);
        w_duty      = (r_duty == '0) ? mts_pkg::DUTY_W'(1) : r_duty;
    end

    // first pass: clk / f, second pass: top / duty
    always_comb begin
        w_div_start    = i_ctl.div_first | i_ctl.div_second;
        w_div_dividend = i_ctl.div_second ? CKW'(r_cand_top) : r_clk_hz;
        w_div_divisor  = i_ctl.div_second ? FREQ_BITS'(w_duty) : w_note_freq;
    end

    mts_div #(
        .DW (CKW),
        .VW (FREQ_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quo      (w_div_quo)
    );

    // clk / (2 p f) equals (clk / f) shifted by log2(2p); quotients fall with
    // p, so the first prescaler whose top lands in 1..255 holds the largest top
    always_comb begin
        w_best_top = mts_pkg::TOP_MAX;
        w_best_sel = mts_pkg::SEL_FALLBACK;
        w_q        = '0;
        for (int i = mts_pkg::NUM_PRE - 1; i >= 0; i--) begin
            w_q = w_div_quo >> mts_pkg::PRE_SHIFT[i];
            if (w_q >= CKW'(2) && w_q <= CKW'(256)) begin
                w_best_top = mts_pkg::TOP_W'(w_q - CKW'(1));
                w_best_sel = mts_pkg::SEL_W'(i + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_idx <= '0;
            r_len       <= '0;
            r_pos       <= '0;
            r_elapsed   <= '0;
            r_busy      <= 1'b0;
            r_pending   <= 1'b0;
            r_fin       <= 1'b0;
            r_en        <= 1'b0;
            r_top       <= '0;
            r_sel       <= mts_pkg::SEL_RESET;
            r_cmp       <= '0;
            r_clk_hz    <= mts_pkg::CLOCK_RESET;
            r_duty      <= mts_pkg::DUTY_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    mts_pkg::CFG_CLOCK: r_clk_hz <= i_cfg_data;
                    mts_pkg::CFG_DUTY:  r_duty   <= i_cfg_data[mts_pkg::DUTY_W-1:0];
                    default: ;
                endcase
            end

            if (i_ctl.emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_ctl.load) begin
                r_fin <= 1'b0;
            end

            if (i_ctl.start && !r_busy) begin
                r_start_idx <= r_idx;
                r_len       <= r_len_in;
                r_pos       <= '0;
                r_elapsed   <= '0;
                r_busy      <= 1'b1;
                r_pending   <= 1'b1;
            end

            if (i_ctl.stop) begin
                r_busy    <= 1'b0;
                r_pending <= 1'b0;
                r_en      <= 1'b0;
            end

            if (i_ctl.idle_tick) begin
                r_en <= 1'b0;
            end

            if (i_ctl.tick) begin
                if (r_pending) begin
                    r_elapsed <= '0;
                    r_pending <= 1'b0;
                end else if (r_elapsed != mts_pkg::ELAPSED_MAX) begin
                    r_elapsed <= r_elapsed + mts_pkg::TICKS_W'(1);
                end
            end

            if (i_ctl.chk && w_reached) begin
                r_pos <= w_pos_inc;
                if (w_pos_inc >= r_len) begin
                    r_busy <= 1'b0;
                    r_en   <= 1'b0;
                    r_fin  <= 1'b1;
                end else begin
                    r_elapsed <= '0;
                end
            end

            if (i_ctl.rest) begin
                r_en <= 1'b0;
            end

            if (i_ctl.fin) begin
                r_en  <= 1'b1;
                r_top <= r_cand_top;
                r_sel <= r_cand_sel;
                r_cmp <= w_div_quo[mts_pkg::TOP_W-1:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd    <= i_command;
            r_idx    <= i_entry_index;
            r_freq   <= FREQ_BITS'(i_note_freq);
            r_ticks  <= i_note_ticks;
            r_len_in <= i_sound_length;
        end
        if (i_ctl.sel) begin
            r_cand_top <= w_best_top;
            r_cand_sel <= w_best_sel;
        end
        if (i_ctl.emit) begin
            r_out_data <= {2'b00, r_fin, r_busy, r_cmp, r_sel, r_top, r_en};
        end
    end

    always_comb begin
        o_sts.cmd      = r_cmd;
        o_sts.busy     = r_busy;
        o_sts.tick_end = w_reached && (w_pos_inc >= r_len);
        o_sts.rest     = (w_note_freq == '0);
        o_sts.div_done = w_div_done;
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### rtl/mts_chk.sv
// port-level checker for the melody tone sequencer result stream, with its bind
// depends on mts_pkg and melody_tone_sequencer_assert.svh
`timescale 1ns / 1ps
`include "melody_tone_sequencer_assert.svh"

module mts_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [mts_pkg::OUT_DATA_W-1:0] i_out_data
);

    // item bits: 0 enable, 8:1 top, 11:9 select, 19:12 compare, 20 playing, 21 finished

    // a sound that just ended is no longer playing and is silent
    `MTS_ASSERT_NOW(a_fin_idle, i_out_valid && i_out_data[21], !i_out_data[20] && !i_out_data[0])

    // the speaker is only driven while a sound is in progress
    `MTS_ASSERT_NOW(a_en_playing, i_out_valid && i_out_data[0], i_out_data[20])

    // prescaler code zero would stop the timer
    `MTS_ASSERT_NOW(a_sel_nonzero, i_out_valid, i_out_data[11:9] != 3'd0)

    // a stalled result item holds
    `MTS_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready,
                     i_out_valid && $stable(i_out_data))

endmodule

bind melody_tone_sequencer mts_chk u_mts_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_m_axis_tvalid),
    .i_out_ready (i_m_axis_tready),
    .i_out_data  (o_m_axis_tdata)
);
